>>> rtl/mstb_pkg.sv
package mstb_pkg;

	localparam int unsigned NUM_TIMERS_DEF = 16;

	typedef enum logic [2:0] {
		CMD_TICK         = 3'd0,
		CMD_START        = 3'd1,
		CMD_DELETE       = 3'd2,
		CMD_PAUSE        = 3'd3,
		CMD_RESUME       = 3'd4,
		CMD_SET_PERIODIC = 3'd5,
		CMD_SET_ROUNDS   = 3'd6,
		CMD_READ_ROUNDS  = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_EXPIRY = 2'd0,
		KIND_ACK    = 2'd1,
		KIND_DONE   = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_WAIT,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [31:0]        period;
		logic signed [32:0] countdown;
		logic [15:0]        rounds;
		logic               paused;
		logic               repeat_on;
		logic               in_use;
	} entry_t;

	localparam entry_t ENTRY_RESET = '{
		period:    32'd0,
		countdown: 33'sd0,
		rounds:    16'd0,
		paused:    1'b0,
		repeat_on: 1'b1,
		in_use:    1'b0
	};

	// Per-slot operation travelling down the update pipeline.
	typedef struct packed {
		logic       valid;
		logic       last;
		logic       is_tick;
		logic       in_range;
		cmd_t       cmd;
		logic [3:0] slot;
	} op_t;

	// Command operands, held stable for the whole transaction.
	typedef struct packed {
		logic [31:0] elapsed;
		logic [31:0] product;
		logic        periodic;
		logic [15:0] rounds_value;
	} ctx_t;

	typedef struct packed {
		logic       valid;
		kind_t      kind;
		logic [3:0] slot;
		logic [15:0] rounds;
		logic       last;
		logic       fin;
	} res_t;

endpackage

>>> rtl/multi_slot_software_timer_bank.sv
// Slot commands: the result passes the ISSUE state, both update stages and the output register; busy until write-back.
// Tick: one slot read per cycle from the slot memory, expiry results stream out in
// slot order, the done result follows; busy until the done result is registered.
// The read-modify-write pipeline is two stages deep; a new transaction waits for it.
// Reset clears all slots (via per-slot valid bits), the held clock and sets ticks
// per ms to 1; the result strobe cannot be stalled by the receiver.
module multi_slot_software_timer_bank #(
	parameter int unsigned NUM_TIMERS = mstb_pkg::NUM_TIMERS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  cmd,
	input  logic [3:0]  timer_index,
	input  logic [31:0] clock_now,
	input  logic [15:0] time_ms,
	input  logic        periodic,
	input  logic [15:0] rounds_value,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	output logic        result_strobe,
	output logic [1:0]  kind,
	output logic [3:0]  slot,
	output logic [15:0] round_count,
	output logic        last
);
	import mstb_pkg::*;

	localparam int unsigned AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int unsigned IW = ((AW > 4) ? AW : 4) + 1;

	state_t        state_q;
	state_t        state_nxt;
	logic [AW-1:0] cnt_q;
	logic [15:0]   ticks_per_ms_q;
	logic [31:0]   last_clock_q;
	logic          is_tick_q;
	cmd_t          cmd_q;
	logic [3:0]    idx_q;
	logic          in_range_q;
	logic [31:0]   elapsed_q;
	logic [31:0]   product_q;
	logic          periodic_q;
	logic [15:0]   rounds_value_q;

	logic          strobe_q;
	kind_t         kind_q;
	logic [3:0]    slot_q;
	logic [15:0]   rounds_q;
	logic          last_q;

	logic          accept;
	logic          issue_last;
	logic [31:0]   product;
	logic [IW-1:0] idx_ext;
	op_t           op_s0;
	logic [AW-1:0] addr_s0;
	logic          rd_en;
	ctx_t          ctx;
	entry_t        rd_data;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	entry_t        wr_data;
	res_t          res;

	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;
	assign product   = time_ms * ticks_per_ms_q;
	assign idx_ext   = IW'(idx_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			cnt_q          <= '0;
			ticks_per_ms_q <= 16'd1;
			last_clock_q   <= '0;
			is_tick_q      <= 1'b0;
			strobe_q       <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_ISSUE) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
			if (cfg_valid && cfg_ready) begin
				ticks_per_ms_q <= cfg_data;
			end
			if (accept) begin
				is_tick_q <= (cmd_t'(cmd) == CMD_TICK);
				if (cmd_t'(cmd) == CMD_TICK) begin
					last_clock_q <= clock_now;
				end
			end
			strobe_q <= res.valid || (state_q == ST_FINISH);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q          <= cmd_t'(cmd);
			idx_q          <= timer_index;
			in_range_q     <= IW'(timer_index) < IW'(NUM_TIMERS);
			elapsed_q      <= clock_now - last_clock_q;
			product_q      <= product;
			periodic_q     <= periodic;
			rounds_value_q <= rounds_value;
		end
		if (state_q == ST_FINISH) begin
			kind_q   <= KIND_DONE;
			slot_q   <= '0;
			rounds_q <= '0;
			last_q   <= 1'b1;
		end else begin
			kind_q   <= res.kind;
			slot_q   <= res.slot;
			rounds_q <= res.rounds;
			last_q   <= res.last;
		end
	end

	assign issue_last = !is_tick_q || (cnt_q == AW'(NUM_TIMERS - 1));

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:   if (accept) state_nxt = ST_ISSUE;
			ST_ISSUE:  if (issue_last) state_nxt = ST_WAIT;
			ST_WAIT:   if (res.fin) state_nxt = is_tick_q ? ST_FINISH : ST_IDLE;
			ST_FINISH: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		busy           = (state_q != ST_IDLE);
		op_s0.valid    = (state_q == ST_ISSUE);
		op_s0.last     = issue_last;
		op_s0.is_tick  = is_tick_q;
		op_s0.in_range = in_range_q;
		op_s0.cmd      = cmd_q;
		op_s0.slot     = is_tick_q ? 4'(cnt_q) : idx_q;
		addr_s0        = is_tick_q ? cnt_q : idx_ext[AW-1:0];
		rd_en          = op_s0.valid && (is_tick_q || in_range_q);
	end

	always_comb begin
		ctx.elapsed      = elapsed_q;
		ctx.product      = product_q;
		ctx.periodic     = periodic_q;
		ctx.rounds_value = rounds_value_q;
	end

	mstb_slot_mem #(
		.NUM_TIMERS (NUM_TIMERS),
		.AW         (AW)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (addr_s0),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	mstb_update #(
		.AW (AW)
	) u_update (
		.clk     (clk),
		.arst_n  (arst_n),
		.op_s0   (op_s0),
		.addr_s0 (addr_s0),
		.ctx     (ctx),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.res     (res)
	);

	assign result_strobe = strobe_q;
	assign kind          = kind_q;
	assign slot          = slot_q;
	assign round_count   = rounds_q;
	assign last          = last_q;

`ifndef SYNTHESIS
	a_wr_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q != ST_IDLE))
		else $error("slot memory written while no transaction is in progress");

	a_res_in_item: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> ((state_q == ST_ISSUE) || (state_q == ST_WAIT)))
		else $error("pipeline result outside a transaction");

	a_done_after_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && (kind_q == KIND_DONE)) |-> ($past(state_q) == ST_FINISH))
		else $error("tick done result without finish state");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("busy not raised after an accepted transaction");
`endif

endmodule

>>> rtl/mstb_slot_mem.sv
module mstb_slot_mem #(
	parameter int unsigned NUM_TIMERS = 16,
	parameter int unsigned AW         = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output mstb_pkg::entry_t rd_data,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  mstb_pkg::entry_t wr_data
);
	import mstb_pkg::*;

	entry_t                mem [NUM_TIMERS];
	entry_t                rdata_q;
	logic                  rvalid_q;
	logic [NUM_TIMERS-1:0] valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q  <= mem[rd_addr];
			rvalid_q <= valid_q[rd_addr];
		end
	end

	// An entry never written since reset reads as the reset slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	assign rd_data = rvalid_q ? rdata_q : ENTRY_RESET;

endmodule

>>> rtl/mstb_update.sv
module mstb_update #(
	parameter int unsigned AW = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  mstb_pkg::op_t    op_s0,
	input  logic [AW-1:0]    addr_s0,
	input  mstb_pkg::ctx_t   ctx,
	input  mstb_pkg::entry_t rd_data,
	output logic             wr_en,
	output logic [AW-1:0]    wr_addr,
	output mstb_pkg::entry_t wr_data,
	output mstb_pkg::res_t   res
);
	import mstb_pkg::*;

	op_t                op_s1;
	op_t                op_s2;
	logic [AW-1:0]      addr_s1;
	logic [AW-1:0]      addr_s2;
	entry_t             entry_s2;
	logic               active_s2;
	logic               expire_s2;

	entry_t             nxt;
	logic               active;
	logic               pos;
	logic               expire;
	logic signed [32:0] sub;
	logic               reload;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= '0;
			op_s2 <= '0;
		end else begin
			op_s1 <= op_s0;
			op_s2 <= op_s1;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1   <= addr_s0;
		addr_s2   <= addr_s1;
		entry_s2  <= nxt;
		active_s2 <= active;
		expire_s2 <= expire;
	end

	// First stage: countdown subtraction for a tick, field update for a command.
	always_comb begin
		nxt    = rd_data;
		active = rd_data.in_use & ~rd_data.paused;
		pos    = ~rd_data.countdown[32] && (rd_data.countdown != '0);
		sub    = rd_data.countdown - $signed({1'b0, ctx.elapsed});
		expire = 1'b0;
		if (op_s1.is_tick) begin
			if (active && pos) begin
				nxt.countdown = sub;
				if (sub[32] || (sub == '0)) begin
					expire     = 1'b1;
					nxt.rounds = rd_data.rounds + 16'd1;
				end
			end
		end else begin
			unique case (op_s1.cmd)
				CMD_START: begin
					nxt.period    = ctx.product;
					nxt.countdown = $signed({1'b0, ctx.product});
					nxt.rounds    = '0;
					nxt.paused    = 1'b0;
					nxt.in_use    = 1'b1;
				end
				CMD_DELETE:       nxt           = ENTRY_RESET;
				CMD_PAUSE:        nxt.paused    = 1'b1;
				CMD_RESUME:       nxt.paused    = 1'b0;
				CMD_SET_PERIODIC: nxt.repeat_on = ctx.periodic;
				CMD_SET_ROUNDS:   nxt.rounds    = ctx.rounds_value;
				CMD_READ_ROUNDS, CMD_TICK: nxt  = rd_data;
			endcase
		end
	end

	// Second stage: reload of an expired or exhausted countdown, then write back.
	always_comb begin
		reload  = active_s2 && (entry_s2.countdown[32] || (entry_s2.countdown == '0));
		wr_data = entry_s2;
		if (op_s2.is_tick && reload) begin
			wr_data.countdown = entry_s2.repeat_on ?
				entry_s2.countdown + $signed({1'b0, entry_s2.period}) : '0;
		end
		wr_addr = addr_s2;
		wr_en   = op_s2.valid && (op_s2.is_tick ? active_s2 :
			(op_s2.in_range && (op_s2.cmd != CMD_READ_ROUNDS)));
	end

	always_comb begin
		res.valid  = op_s2.valid && (!op_s2.is_tick || expire_s2);
		res.kind   = op_s2.is_tick ? KIND_EXPIRY : KIND_ACK;
		res.slot   = op_s2.slot;
		res.rounds = (op_s2.is_tick || op_s2.in_range) ? entry_s2.rounds : '0;
		res.last   = ~op_s2.is_tick;
		res.fin    = op_s2.valid && op_s2.last;
	end

endmodule
